FILE: rtl/wfgdd_pkg.sv
// Package for the wait-for graph deadlock detector.
// Holds opcodes, status codes and command/status structs; no dependencies.
`timescale 1ns / 1ps
package wfgdd_pkg;
	localparam logic [1:0] OP_REQUEST  = 2'd0;
	localparam logic [1:0] OP_ACQUIRED = 2'd1;
	localparam logic [1:0] OP_UNLOCK   = 2'd2;
	localparam logic [1:0] OP_CHECK    = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_CYCLE = 2'd1;
	localparam logic [1:0] ST_NONE  = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [4:0] WAIT_MAX = 5'd31;

	typedef struct packed {
		logic start;
		logic scan_step;
		logic apply;
		logic dfs_init;
		logic dfs_step;
		logic emit_step;
	} wfgdd_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic dfs_done;
		logic dfs_found;
		logic emit_done;
	} wfgdd_sts_t;
endpackage

FILE: rtl/wait_for_graph_deadlock_detector_unit.sv
// A lock event runs a serial scan of the lock table followed by a serial scan of
// the vertex table, then applies the update and emits its result; the next
// transaction is accepted once that result has moved into the output register.
// A check walks the graph depth first, trying roots, examining edges and leaving
// vertices, then emits its results one at a time. One transaction is in work at
// a time; the result register lets the next input be taken while a result waits.
// Depends on wfgdd_pkg, wfgdd_ctrl and wfgdd_datapath.
`timescale 1ns / 1ps
module wait_for_graph_deadlock_detector_unit #(
	parameter int VERTICES = 16,
	parameter int LOCKS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // op[1:0], thread_id[65:2], mutex[129:66]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // status[1:0], cycle_thread[65:2]
	output logic         m_tlast
);
	import wfgdd_pkg::*;

	wfgdd_cmd_t cmd;
	wfgdd_sts_t sts;
	logic busy, emit_valid, emit_kind, out_free, in_fire;
	logic [1:0] r_status;
	logic [63:0] r_thread;
	logic r_last;
	logic mv_q;
	logic [65:0] md_q;
	logic ml_q;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !mv_q || m_tready;

	wfgdd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(s_tdata[1:0]),
		.out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy),
		.emit_valid(emit_valid), .emit_kind(emit_kind)
	);

	wfgdd_datapath #(.VERTICES(VERTICES), .LOCKS(LOCKS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_op(s_tdata[1:0]), .in_tid(s_tdata[65:2]), .in_addr(s_tdata[129:66]),
		.res_status(r_status), .res_thread(r_thread), .res_last(r_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_q <= 1'b0;
		end else if (out_free) begin
			mv_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_valid) begin
			md_q <= {r_thread, r_status};
			ml_q <= r_last;
		end
	end

	assign m_tvalid = mv_q;
	assign m_tdata = {6'd0, md_q};
	assign m_tlast = ml_q;

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_CYCLE |-> m_tlast)
		else $error("non-cycle result without last");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit_valid |-> !s_tready)
		else $error("input taken while a result is pending");
	a_cycle_kind: assert property (@(posedge clk) disable iff (!arst_n)
		emit_kind |-> r_status == ST_CYCLE)
		else $error("cycle emission with wrong status");
endmodule

FILE: rtl/wfgdd_ctrl.sv
// Controller state machine for the deadlock detector.
// Depends on wfgdd_pkg; drives the datapath by command struct.
`timescale 1ns / 1ps
module wfgdd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [1:0]           in_op,
	input  logic                 out_free,
	input  wfgdd_pkg::wfgdd_sts_t sts,
	output wfgdd_pkg::wfgdd_cmd_t cmd,
	output logic                 busy,
	output logic                 emit_valid,
	output logic                 emit_kind
);
	import wfgdd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_DONE = 3'd3;
	localparam logic [2:0] S_DFS = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;
	localparam logic [2:0] S_NONE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		emit_valid = 1'b0;
		emit_kind = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.start = 1'b1;
					state_d = (in_op == OP_CHECK) ? S_DFS : S_SCAN;
					cmd.dfs_init = (in_op == OP_CHECK);
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				emit_valid = 1'b1;
				if (out_free) state_d = S_IDLE;
			end
			S_DFS: begin
				if (sts.dfs_found) state_d = S_EMIT;
				else if (sts.dfs_done) state_d = S_NONE;
				else cmd.dfs_step = 1'b1;
			end
			S_EMIT: begin
				emit_valid = 1'b1;
				emit_kind = 1'b1;
				if (out_free) begin
					cmd.emit_step = 1'b1;
					if (sts.emit_done) state_d = S_IDLE;
				end
			end
			S_NONE: begin
				emit_valid = 1'b1;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

FILE: rtl/wfgdd_datapath.sv
// Datapath of the deadlock detector: lock table, vertex table, edge matrix and
// depth-first walker. Depends on wfgdd_pkg; sequenced by wfgdd_ctrl.
`timescale 1ns / 1ps
module wfgdd_datapath #(
	parameter int VERTICES = 16,
	parameter int LOCKS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wfgdd_pkg::wfgdd_cmd_t cmd,
	output wfgdd_pkg::wfgdd_sts_t sts,
	input  logic [1:0]            in_op,
	input  logic [63:0]           in_tid,
	input  logic [63:0]           in_addr,
	output logic [1:0]            res_status,
	output logic [63:0]           res_thread,
	output logic                  res_last
);
	import wfgdd_pkg::*;

	localparam int VW = $clog2(VERTICES);
	localparam int CW = $clog2(VERTICES + 1);
	localparam int LW = $clog2(LOCKS);
	localparam int SW = (VERTICES > LOCKS) ? CW : $clog2(LOCKS + 1);

	logic [63:0] vid_q [VERTICES];
	logic [CW-1:0] vcnt_q;
	logic [VERTICES-1:0] edge_q [VERTICES];
	logic [63:0] laddr_q [LOCKS];
	logic [63:0] lown_q [LOCKS];
	logic [LOCKS-1:0] lval_q;
	logic [4:0] wcnt_q [LOCKS];

	logic [1:0] op_q;
	logic [63:0] tid_q, addr_q;
	logic [SW-1:0] scan_q;
	logic lfound_q, ffound_q;
	logic [LW-1:0] lidx_q, fidx_q;
	logic [1:0] st_q;

	// Second scan pass resolves vertices of thread and owner.
	logic pass_q;
	logic a_f_q, b_f_q;
	logic [VW-1:0] a_q, b_q;
	logic [63:0] own_q;

	logic [VERTICES-1:0] live;
	always_comb begin
		for (int i = 0; i < VERTICES; i++) live[i] = (i < vcnt_q);
	end

	logic [SW-1:0] scan_end;
	assign scan_end = pass_q ? SW'(VERTICES) : SW'(LOCKS);
	assign sts.scan_done = pass_q && (scan_q == SW'(VERTICES) - SW'(1));

	// DFS state.
	logic [VW-1:0] path_q [VERTICES];
	logic [VERTICES-1:0] rem_q [VERTICES];
	logic [CW-1:0] sp_q;
	logic [VERTICES-1:0] onp_q, done_q;
	logic [CW-1:0] root_q;
	logic found_q, fin_q;
	logic [CW-1:0] ep_q;
	logic [VW-1:0] ej_q;

	assign sts.dfs_found = found_q;
	assign sts.dfs_done = fin_q;
	assign sts.emit_done = (ep_q == sp_q);

	logic [VW-1:0] top_v;
	logic [VERTICES-1:0] top_rem;
	logic [VW-1:0] pj;
	logic pj_any;
	logic [CW-1:0] fp;
	always_comb begin
		top_v = path_q[VW'(sp_q - CW'(1))];
		top_rem = rem_q[VW'(sp_q - CW'(1))];
		pj = '0;
		pj_any = 1'b0;
		for (int j = VERTICES - 1; j >= 0; j--) begin
			if (top_rem[j]) begin
				pj = VW'(j);
				pj_any = 1'b1;
			end
		end
		fp = '0;
		for (int p = VERTICES - 1; p >= 0; p--)
			if (CW'(p) < sp_q && path_q[p] == pj) fp = CW'(p);
	end

	always_comb begin
		if (found_q) begin
			res_status = ST_CYCLE;
			res_thread = (ep_q == sp_q) ? vid_q[ej_q] : vid_q[path_q[VW'(ep_q)]];
			res_last = (ep_q == sp_q);
		end else if (fin_q) begin
			res_status = ST_NONE;
			res_thread = '0;
			res_last = 1'b1;
		end else begin
			res_status = st_q;
			res_thread = '0;
			res_last = 1'b1;
		end
	end

	logic [LW-1:0] sl;
	logic [VW-1:0] sv;
	assign sl = LW'(scan_q);
	assign sv = VW'(scan_q);

	logic [1:0] need;
	logic [LW-1:0] li;
	logic [VW-1:0] an, bn;
	logic [VERTICES-1:0] a_row;
	logic req_full, acq_full;
	logic [1:0] apply_st;
	always_comb begin
		li = lidx_q;
		need = 2'd0;
		if (!a_f_q) need = need + 2'd1;
		if (own_q != tid_q && !b_f_q) need = need + 2'd1;
		an = a_f_q ? a_q : VW'(vcnt_q);
		bn = b_f_q ? b_q
			: ((own_q == tid_q) ? an
			: VW'(vcnt_q + CW'(a_f_q ? 0 : 1)));
		a_row = a_f_q ? edge_q[an] : '0;
		if (an != bn) a_row[bn] = 1'b1;
		req_full = ((CW+1)'(vcnt_q) + (CW+1)'(need) > (CW+1)'(VERTICES));
		acq_full = !ffound_q;
		apply_st = ST_DONE;
		if (addr_q != 64'd0) begin
			if (op_q == OP_REQUEST && lfound_q && req_full) apply_st = ST_FULL;
			if (op_q == OP_ACQUIRED && !lfound_q && acq_full) apply_st = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= '0;
			lval_q <= '0;
			for (int i = 0; i < VERTICES; i++) edge_q[i] <= '0;
			for (int i = 0; i < LOCKS; i++) wcnt_q[i] <= '0;
			found_q <= 1'b0;
			fin_q <= 1'b0;
			st_q <= ST_DONE;
			pass_q <= 1'b0;
			scan_q <= '0;
		end else begin
			if (cmd.start) begin
				op_q <= in_op;
				tid_q <= in_tid;
				addr_q <= in_addr;
				scan_q <= '0;
				pass_q <= 1'b0;
				lfound_q <= 1'b0;
				ffound_q <= 1'b0;
				a_f_q <= 1'b0;
				b_f_q <= 1'b0;
				found_q <= 1'b0;
				fin_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (!pass_q) begin
					if (lval_q[sl] && laddr_q[sl] == addr_q && !lfound_q) begin
						lfound_q <= 1'b1;
						lidx_q <= sl;
						own_q <= lown_q[sl];
					end
					if (!lval_q[sl] && !ffound_q) begin
						ffound_q <= 1'b1;
						fidx_q <= sl;
					end
					if (scan_q == scan_end - SW'(1)) begin
						pass_q <= 1'b1;
						scan_q <= '0;
					end else scan_q <= scan_q + SW'(1);
				end else begin
					if (live[sv] && vid_q[sv] == tid_q && !a_f_q) begin
						a_f_q <= 1'b1;
						a_q <= sv;
					end
					if (live[sv] && vid_q[sv] == own_q && !b_f_q) begin
						b_f_q <= 1'b1;
						b_q <= sv;
					end
					scan_q <= scan_q + SW'(1);
				end
			end
			if (cmd.apply) begin
				st_q <= apply_st;
				if (addr_q != 64'd0) begin
					unique case (op_q)
						OP_REQUEST: begin
							if (lfound_q && !req_full) begin
								if (!a_f_q) vid_q[an] <= tid_q;
								if (!b_f_q && own_q != tid_q) begin
									vid_q[bn] <= own_q;
									edge_q[bn] <= '0;
								end
								edge_q[an] <= a_row;
								vcnt_q <= vcnt_q + CW'(need);
								if (wcnt_q[li] < WAIT_MAX) wcnt_q[li] <= wcnt_q[li] + 5'd1;
							end
						end
						OP_ACQUIRED: begin
							if (!lfound_q) begin
								if (ffound_q) begin
									lval_q[fidx_q] <= 1'b1;
									laddr_q[fidx_q] <= addr_q;
									lown_q[fidx_q] <= tid_q;
									wcnt_q[fidx_q] <= '0;
								end
							end else begin
								if (wcnt_q[li] != 5'd0) wcnt_q[li] <= wcnt_q[li] - 5'd1;
								if (a_f_q && b_f_q) edge_q[a_q][b_q] <= 1'b0;
								lown_q[li] <= tid_q;
							end
						end
						OP_UNLOCK: begin
							if (lfound_q && wcnt_q[li] == 5'd0) lval_q[li] <= 1'b0;
						end
						default: ;
					endcase
				end
			end
			if (cmd.dfs_init) begin
				sp_q <= '0;
				onp_q <= '0;
				done_q <= '0;
				root_q <= '0;
			end
			if (cmd.dfs_step) begin
				if (sp_q == CW'(0)) begin
					if (root_q >= vcnt_q) fin_q <= 1'b1;
					else begin
						if (!done_q[VW'(root_q)]) begin
							path_q[0] <= VW'(root_q);
							rem_q[0] <= edge_q[VW'(root_q)] & live;
							onp_q[VW'(root_q)] <= 1'b1;
							sp_q <= CW'(1);
						end
						root_q <= root_q + CW'(1);
					end
				end else if (!pj_any) begin
					onp_q[top_v] <= 1'b0;
					done_q[top_v] <= 1'b1;
					sp_q <= sp_q - CW'(1);
				end else begin
					rem_q[VW'(sp_q - CW'(1))][pj] <= 1'b0;
					if (onp_q[pj]) begin
						found_q <= 1'b1;
						ej_q <= pj;
						ep_q <= fp;
					end else if (!done_q[pj] && sp_q < CW'(VERTICES)) begin
						path_q[VW'(sp_q)] <= pj;
						rem_q[VW'(sp_q)] <= edge_q[pj] & live;
						onp_q[pj] <= 1'b1;
						sp_q <= sp_q + CW'(1);
					end
				end
			end
			if (cmd.emit_step && ep_q != sp_q) ep_q <= ep_q + CW'(1);
		end
	end
endmodule
